// ===== src/dvrt_pkg.sv =====
// shared types and constants for the distance-vector route table
package dvrt_pkg;

    localparam int DEF_NUM_ADDRESSES = 256;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [7:0] NO_HOP        = 8'd255;
    localparam logic [7:0] RST_HOP_LIMIT = 8'd16;
    localparam logic [7:0] RST_TIMEOUT   = 8'd12;

    localparam logic [1:0] FUNC_HELLO  = 2'd0;
    localparam logic [1:0] FUNC_UPDATE = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP = 2'd2;
    localparam logic [1:0] FUNC_TICK   = 2'd3;

    localparam logic CFG_HOP_LIMIT = 1'b0;
    localparam logic CFG_TIMEOUT   = 1'b1;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  from_mip;
        logic [7:0]  target_mip;
        logic [7:0]  pair_distance;
        logic [31:0] now_seconds;
    } t_in_word;

    typedef struct packed {
        logic       changed;
        logic [7:0] next_hop;
    } t_out_word;

    typedef enum logic [2:0] {
        OP_HELLO  = 3'd0,
        OP_UPDATE = 3'd1,
        OP_LOOKUP = 3'd2,
        OP_TICK   = 3'd3,
        OP_IGNORE = 3'd4
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  addr;
        logic [7:0]  from_mip;
        logic [7:0]  pair_dist;
        logic [31:0] now;
    } t_cmd;

    typedef struct packed {
        logic [7:0]  distance;
        logic [7:0]  next_hop;
        logic [31:0] last_heard;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ===== src/dvrt_ram.sv =====
// generic simple dual-port ram with registered read
module dvrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/dvrt_front.sv =====
// front end: takes words, classifies them and queues commands
module dvrt_front import dvrt_pkg::*; #(
    parameter int NUM_ADDRESSES = DEF_NUM_ADDRESSES
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_in_word i_word,
    output logic     o_busy,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_pop
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_q [QUEUE_DEPTH];
    logic [QW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          w_push;
    t_cmd          w_cmd;

    function automatic logic in_range(input logic [7:0] a);
        in_range = 32'(a) < NUM_ADDRESSES;
    endfunction

    function automatic logic [QW-1:0] ptr_inc(input logic [QW-1:0] p);
        if (p == QW'(QUEUE_DEPTH - 1)) begin
            ptr_inc = '0;
        end else begin
            ptr_inc = p + QW'(1);
        end
    endfunction

    assign o_busy = (r_count == CW'(QUEUE_DEPTH));
    assign w_push = i_start && !o_busy;

    // addresses beyond the table turn the word into a no-op
    always_comb begin
        w_cmd.from_mip  = i_word.from_mip;
        w_cmd.pair_dist = i_word.pair_distance;
        w_cmd.now       = i_word.now_seconds;
        w_cmd.addr      = i_word.target_mip;
        case (i_word.func)
            FUNC_HELLO: begin
                w_cmd.addr = i_word.from_mip;
                w_cmd.op   = in_range(i_word.from_mip) ? OP_HELLO : OP_IGNORE;
            end
            FUNC_UPDATE: begin
                w_cmd.op = (in_range(i_word.from_mip) && in_range(i_word.target_mip)) ?
                           OP_UPDATE : OP_IGNORE;
            end
            FUNC_LOOKUP: begin
                w_cmd.op = in_range(i_word.target_mip) ? OP_LOOKUP : OP_IGNORE;
            end
            default: begin
                w_cmd.op = OP_TICK;
            end
        endcase
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = ptr_inc(r_wr_ptr);
        end
        if (i_cmd_pop) begin
            n_rd_ptr = ptr_inc(r_rd_ptr);
        end
        if (w_push && !i_cmd_pop) begin
            n_count = r_count + CW'(1);
        end else if (!w_push && i_cmd_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

endmodule

// ===== src/dvrt_back.sv =====
// back end: table read-modify-write, timeout scan and result register
module dvrt_back import dvrt_pkg::*; #(
    parameter int NUM_ADDRESSES = DEF_NUM_ADDRESSES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    input  logic [7:0] i_hop_limit,
    input  logic [7:0] i_timeout,
    output logic       o_strobe,
    output t_out_word  o_word
);

    localparam int AW = (NUM_ADDRESSES > 1) ? $clog2(NUM_ADDRESSES) : 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state                   r_state, n_state;
    t_cmd                     r_cmd, n_cmd;
    logic [AW-1:0]            r_scan, n_scan;
    logic                     r_sv, n_sv;
    logic [AW-1:0]            r_saddr, n_saddr;
    logic                     r_any, n_any;
    logic                     r_strobe, n_strobe;
    t_out_word                r_word, n_word;
    logic [NUM_ADDRESSES-1:0] r_valid;

    logic                     w_we;
    logic [AW-1:0]            w_waddr;
    t_entry                   w_wdata;
    logic [AW-1:0]            w_raddr;
    logic [ENTRY_W-1:0]       w_rdata;
    t_entry                   w_rd;
    logic                     w_set_valid;
    logic                     w_mark;
    logic                     w_ent_valid;
    logic [8:0]               w_nd_full;
    logic [7:0]               w_nd;

    dvrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_ADDRESSES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd        = t_entry'(w_rdata);
    assign w_ent_valid = r_valid[r_cmd.addr[AW-1:0]];

    // advertised distance plus one, saturated
    assign w_nd_full = {1'b0, r_cmd.pair_dist} + 9'd1;
    assign w_nd      = (w_nd_full > {1'b0, i_hop_limit}) ? i_hop_limit : w_nd_full[7:0];

    // scan stage: data for r_saddr arrived this cycle
    assign w_mark = r_sv && r_valid[r_saddr] && (w_rd.distance == 8'd1) &&
                    ((r_cmd.now - w_rd.last_heard) > {24'd0, i_timeout});

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_scan      = r_scan;
        n_sv        = 1'b0;
        n_saddr     = r_scan;
        n_any       = r_any;
        n_strobe    = 1'b0;
        n_word      = r_word;
        w_we        = 1'b0;
        w_waddr     = r_cmd.addr[AW-1:0];
        w_wdata     = w_rd;
        w_raddr     = r_scan;
        w_set_valid = 1'b0;
        o_cmd_pop   = 1'b0;

        if (w_mark) begin
            w_we             = 1'b1;
            w_waddr          = r_saddr;
            w_wdata.distance = i_hop_limit;
            n_any            = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                w_raddr = i_cmd.addr[AW-1:0];
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    if (i_cmd.op == OP_TICK) begin
                        n_state = S_SCAN;
                        n_scan  = '0;
                        n_any   = 1'b0;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_SCAN: begin
                w_raddr = r_scan;
                n_sv    = 1'b1;
                n_saddr = r_scan;
                if (r_scan == AW'(NUM_ADDRESSES - 1)) begin
                    n_state = S_FLUSH;
                end else begin
                    n_scan = r_scan + AW'(1);
                end
            end
            S_FLUSH: begin
                n_strobe        = 1'b1;
                n_word.changed  = r_any || w_mark;
                n_word.next_hop = NO_HOP;
                n_state         = S_IDLE;
            end
            S_EXEC: begin
                n_strobe        = 1'b1;
                n_word.changed  = 1'b0;
                n_word.next_hop = NO_HOP;
                n_state         = S_IDLE;
                case (r_cmd.op)
                    OP_HELLO: begin
                        n_word.changed = !w_ent_valid || (w_rd.distance != 8'd1) ||
                                         (w_rd.next_hop != r_cmd.from_mip);
                        w_we        = 1'b1;
                        w_set_valid = 1'b1;
                        w_wdata     = '{distance: 8'd1, next_hop: r_cmd.from_mip,
                                        last_heard: r_cmd.now};
                    end
                    OP_UPDATE: begin
                        if (!w_ent_valid) begin
                            n_word.changed = 1'b1;
                            w_we           = 1'b1;
                            w_set_valid    = 1'b1;
                            w_wdata        = '{distance: w_nd, next_hop: r_cmd.from_mip,
                                               last_heard: r_cmd.now};
                        end else if ((r_cmd.pair_dist >= i_hop_limit) &&
                                     (w_rd.next_hop == r_cmd.from_mip)) begin
                            // poisoned by the current next hop
                            if (w_rd.distance != i_hop_limit) begin
                                n_word.changed   = 1'b1;
                                w_we             = 1'b1;
                                w_wdata.distance = i_hop_limit;
                            end
                        end else if (w_rd.distance > w_nd) begin
                            n_word.changed   = 1'b1;
                            w_we             = 1'b1;
                            w_wdata.distance = w_nd;
                            w_wdata.next_hop = r_cmd.from_mip;
                        end
                    end
                    OP_LOOKUP: begin
                        if (w_ent_valid && (w_rd.distance < i_hop_limit)) begin
                            n_word.next_hop = w_rd.next_hop;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sv     <= 1'b0;
            r_strobe <= 1'b0;
            r_valid  <= '0;
        end else begin
            r_state  <= n_state;
            r_sv     <= n_sv;
            r_strobe <= n_strobe;
            if (w_set_valid) begin
                r_valid[w_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_scan  <= n_scan;
        r_saddr <= n_saddr;
        r_any   <= n_any;
        r_word  <= n_word;
    end

    assign o_strobe = r_strobe;
    assign o_word   = r_word;

endmodule

// ===== src/distance_vector_route_table.sv =====
// top level of the distance-vector route table
//
// Words are taken at a rising edge with start high and busy low, and go into a two-entry
// command queue; busy is high while that queue is full. Every word gives exactly one result,
// shown on o_word for a single cycle with o_strobe high; the receiver cannot stall, so
// results must be taken as they come. Hello, update and lookup words get a ram read in the
// idle state, then the compare and write-back in exec, before the next word is taken. A
// timeout tick sweeps the whole table through the ram read port, one entry a cycle. The
// result is registered and appears in the cycle after the back end finishes the word.
// Valid bits are cleared by reset at once, so the block is usable from the first cycle
// after reset. The user must write the hop limit (index 0) and the timeout (index 1)
// through the plain write port only while the block is idle; the block does not enforce it.
module distance_vector_route_table import dvrt_pkg::*; #(
    parameter int NUM_ADDRESSES = DEF_NUM_ADDRESSES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_in_word   i_word,
    output logic       o_strobe,
    output t_out_word  o_word,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic [7:0] r_hop_limit;
    logic [7:0] r_timeout;
    logic       w_cmd_valid;
    t_cmd       w_cmd;
    logic       w_cmd_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hop_limit <= RST_HOP_LIMIT;
            r_timeout   <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HOP_LIMIT: r_hop_limit <= i_cfg_data;
                CFG_TIMEOUT:   r_timeout   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dvrt_front #(
        .NUM_ADDRESSES (NUM_ADDRESSES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_word      (i_word),
        .o_busy      (busy),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    dvrt_back #(
        .NUM_ADDRESSES (NUM_ADDRESSES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_hop_limit (r_hop_limit),
        .i_timeout   (r_timeout),
        .o_strobe    (o_strobe),
        .o_word      (o_word)
    );

endmodule

// ===== verif/distance_vector_route_table_tb.sv =====
// self-checking testbench for the distance-vector route table, predictor scored
`timescale 1ns / 100ps

module distance_vector_route_table_tb import dvrt_pkg::*;;

    localparam int ADDR_COUNT = DEF_NUM_ADDRESSES;

    typedef struct {
        t_in_word  w;
        bit        has_exp;
        t_out_word exp;
    } t_dir_row;

    typedef struct {
        logic [7:0] max_dist;
        logic [7:0] timeout;
        int         idle_pct;
        int         n_words;
    } t_phase;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_word  i_word = '0;
    logic      o_strobe;
    t_out_word o_word;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_index = CFG_HOP_LIMIT;
    logic [7:0] i_cfg_data = '0;

    // shadow copy of the route table and its registers
    bit          rt_valid [ADDR_COUNT];
    logic [7:0]  rt_dist  [ADDR_COUNT];
    logic [7:0]  rt_hop   [ADDR_COUNT];
    logic [31:0] rt_heard [ADDR_COUNT];
    logic [7:0]  cfg_max_dist = RST_HOP_LIMIT;
    logic [7:0]  cfg_timeout  = RST_TIMEOUT;

    t_out_word   route_exp_q [$];
    int          err_count = 0;

    logic [7:0]  addr_pool [8];
    logic [31:0] run_clock;

    distance_vector_route_table i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_word      (i_word),
        .o_strobe    (o_strobe),
        .o_word      (o_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // every 8-bit address is inside the table at the default size
    function automatic t_out_word route_predict(input t_in_word w);
        t_out_word   r;
        logic [8:0]  nd;
        logic [31:0] age;
        logic [7:0]  t;
        t = w.target_mip;
        r.changed  = 1'b0;
        r.next_hop = NO_HOP;
        case (w.func)
            FUNC_HELLO: begin
                r.changed = !rt_valid[w.from_mip] || rt_dist[w.from_mip] != 8'd1 ||
                            rt_hop[w.from_mip] != w.from_mip;
                rt_valid[w.from_mip] = 1'b1;
                rt_dist[w.from_mip]  = 8'd1;
                rt_hop[w.from_mip]   = w.from_mip;
                rt_heard[w.from_mip] = w.now_seconds;
            end
            FUNC_UPDATE: begin
                nd = {1'b0, w.pair_distance} + 9'd1;
                if (nd > {1'b0, cfg_max_dist})
                    nd = {1'b0, cfg_max_dist};
                if (!rt_valid[t]) begin
                    rt_valid[t] = 1'b1;
                    rt_dist[t]  = nd[7:0];
                    rt_hop[t]   = w.from_mip;
                    rt_heard[t] = w.now_seconds;
                    r.changed   = 1'b1;
                end else if (w.pair_distance >= cfg_max_dist && rt_hop[t] == w.from_mip) begin
                    // poisoned by the current next hop
                    if (rt_dist[t] != cfg_max_dist) begin
                        rt_dist[t] = cfg_max_dist;
                        r.changed  = 1'b1;
                    end
                end else if ({1'b0, rt_dist[t]} > nd) begin
                    rt_dist[t] = nd[7:0];
                    rt_hop[t]  = w.from_mip;
                    r.changed  = 1'b1;
                end
            end
            FUNC_LOOKUP: begin
                if (rt_valid[t] && rt_dist[t] < cfg_max_dist)
                    r.next_hop = rt_hop[t];
            end
            default: begin
                for (int a = 0; a < ADDR_COUNT; a++) begin
                    if (rt_valid[a] && rt_dist[a] == 8'd1) begin
                        age = w.now_seconds - rt_heard[a];
                        if (age > {24'd0, cfg_timeout}) begin
                            rt_dist[a] = cfg_max_dist;
                            r.changed  = 1'b1;
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic t_dir_row dir_row(input logic [1:0] f, input logic [7:0] fr,
                                         input logic [7:0] tg, input logic [7:0] d,
                                         input logic [31:0] t, input bit has_exp,
                                         input logic chg, input logic [7:0] hop);
        t_dir_row r;
        r.w.func          = f;
        r.w.from_mip      = fr;
        r.w.target_mip    = tg;
        r.w.pair_distance = d;
        r.w.now_seconds   = t;
        r.has_exp         = has_exp;
        r.exp.changed     = chg;
        r.exp.next_hop    = hop;
        return r;
    endfunction

    function automatic logic [7:0] pick_addr();
        if ($urandom_range(9) < 8)
            return addr_pool[$urandom_range(7)];
        return 8'($urandom_range(255));
    endfunction

    // start stays high across back-to-back words
    task automatic send_word(input t_in_word w, input bit has_exp, input t_out_word fixed_res,
                             input int idle_pct);
        t_out_word p;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start  <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (busy);
        p = route_predict(w);
        route_exp_q.push_back(has_exp ? fixed_res : p);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (route_exp_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [7:0] max_dist, input logic [7:0] timeout);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_HOP_LIMIT;
        i_cfg_data  <= max_dist;
        @(posedge i_clk);
        i_cfg_index <= CFG_TIMEOUT;
        i_cfg_data  <= timeout;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_max_dist = max_dist;
        cfg_timeout  = timeout;
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_word want;
        if (i_rst_n && o_strobe) begin
            if (route_exp_q.size() == 0) begin
                $error("result word with none expected: changed %0d next_hop %0d",
                       o_word.changed, o_word.next_hop);
                err_count++;
            end else begin
                want = route_exp_q.pop_front();
                if (o_word.changed !== want.changed) begin
                    $error("changed: expected %0d, actual %0d", want.changed, o_word.changed);
                    err_count++;
                end
                if (o_word.next_hop !== want.next_hop) begin
                    $error("next_hop: expected %0d, actual %0d", want.next_hop, o_word.next_hop);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        t_dir_row   rows [$];
        t_phase     phases [6];
        t_in_word   w;
        t_out_word  none;
        int         fsel;

        none = '0;
        for (int a = 0; a < ADDR_COUNT; a++) begin
            rt_valid[a] = 1'b0;
            rt_dist[a]  = '0;
            rt_hop[a]   = '0;
            rt_heard[a] = '0;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words at the reset register values
        rows.push_back(dir_row(FUNC_LOOKUP, 8'd0, 8'd0, 8'd0, 32'd0, 1'b1, 1'b0, NO_HOP));
        rows.push_back(dir_row(FUNC_TICK, 8'd0, 8'd0, 8'd0, 32'd0, 1'b1, 1'b0, NO_HOP));
        rows.push_back(dir_row(FUNC_HELLO, 8'd0, 8'd0, 8'd0, 32'd100, 1'b1, 1'b1, NO_HOP));
        rows.push_back(dir_row(FUNC_HELLO, 8'd255, 8'd255, 8'd255, 32'd100, 1'b1, 1'b1,
                               NO_HOP));
        rows.push_back(dir_row(FUNC_HELLO, 8'd0, 8'd0, 8'd0, 32'd101, 1'b1, 1'b0, NO_HOP));
        rows.push_back(dir_row(FUNC_LOOKUP, 8'd0, 8'd0, 8'd0, 32'd101, 1'b1, 1'b0, 8'd0));
        rows.push_back(dir_row(FUNC_LOOKUP, 8'd0, 8'd255, 8'd0, 32'd101, 1'b1, 1'b0, NO_HOP));
        rows.push_back(dir_row(FUNC_UPDATE, 8'd0, 8'd10, 8'd3, 32'd102, 1'b0, 1'b0, NO_HOP));
        rows.push_back(dir_row(FUNC_UPDATE, 8'd255, 8'd10, 8'd1, 32'd102, 1'b0, 1'b0, NO_HOP));
        rows.push_back(dir_row(FUNC_UPDATE, 8'd0, 8'd10, 8'd0, 32'd102, 1'b0, 1'b0, NO_HOP));
        rows.push_back(dir_row(FUNC_UPDATE, 8'd0, 8'd10, 8'd255, 32'd103, 1'b0, 1'b0, NO_HOP));
        rows.push_back(dir_row(FUNC_UPDATE, 8'd0, 8'd10, 8'd255, 32'd103, 1'b0, 1'b0, NO_HOP));
        rows.push_back(dir_row(FUNC_LOOKUP, 8'd0, 8'd10, 8'd0, 32'd103, 1'b0, 1'b0, NO_HOP));
        rows.push_back(dir_row(FUNC_UPDATE, 8'd7, 8'd20, 8'd255, 32'd104, 1'b0, 1'b0, NO_HOP));
        rows.push_back(dir_row(FUNC_UPDATE, 8'd7, 8'd20, 8'd254, 32'd104, 1'b0, 1'b0, NO_HOP));
        rows.push_back(dir_row(FUNC_UPDATE, 8'd9, 8'd0, 8'd0, 32'd104, 1'b0, 1'b0, NO_HOP));
        rows.push_back(dir_row(FUNC_HELLO, 8'd20, 8'd0, 8'd0, 32'd105, 1'b0, 1'b0, NO_HOP));
        // age equal to the timeout keeps a neighbour, one more second drops it
        rows.push_back(dir_row(FUNC_TICK, 8'd0, 8'd0, 8'd0, 32'd113, 1'b0, 1'b0, NO_HOP));
        rows.push_back(dir_row(FUNC_TICK, 8'd0, 8'd0, 8'd0, 32'd114, 1'b0, 1'b0, NO_HOP));
        rows.push_back(dir_row(FUNC_LOOKUP, 8'd0, 8'd0, 8'd0, 32'd114, 1'b0, 1'b0, NO_HOP));
        rows.push_back(dir_row(FUNC_LOOKUP, 8'd0, 8'd255, 8'd0, 32'd114, 1'b0, 1'b0, NO_HOP));
        // age across the 32-bit wrap
        rows.push_back(dir_row(FUNC_HELLO, 8'd30, 8'd0, 8'd0, 32'hFFFF_FFFF, 1'b0, 1'b0,
                               NO_HOP));
        rows.push_back(dir_row(FUNC_TICK, 8'd0, 8'd0, 8'd0, 32'd20, 1'b0, 1'b0, NO_HOP));
        rows.push_back(dir_row(FUNC_UPDATE, 8'd31, 8'd30, 8'd254, 32'd21, 1'b0, 1'b0, NO_HOP));
        rows.push_back(dir_row(FUNC_UPDATE, 8'd30, 8'd30, 8'd255, 32'd21, 1'b0, 1'b0, NO_HOP));

        foreach (rows[i])
            send_word(rows[i].w, rows[i].has_exp, rows[i].exp, 0);

        phases[0] = '{RST_HOP_LIMIT, RST_TIMEOUT, 0, 300};
        phases[1] = '{8'd1, 8'd1, 75, 250};
        phases[2] = '{8'd255, 8'd255, 0, 300};
        phases[3] = '{8'd255, 8'd1, 36, 250};
        phases[4] = '{8'd1, 8'd255, 75, 250};
        phases[5] = '{8'($urandom_range(254, 2)), 8'($urandom_range(254, 2)), 36, 500};

        run_clock = $urandom;
        foreach (phases[p]) begin
            drain_results();
            write_regs(phases[p].max_dist, phases[p].timeout);
            addr_pool[0] = 8'd0;
            addr_pool[1] = 8'd255;
            for (int k = 2; k < 8; k++)
                addr_pool[k] = 8'($urandom_range(255));

            for (int n = 0; n < phases[p].n_words; n++) begin
                fsel = $urandom_range(99);
                if (fsel < 25)
                    w.func = FUNC_HELLO;
                else if (fsel < 65)
                    w.func = FUNC_UPDATE;
                else if (fsel < 92)
                    w.func = FUNC_LOOKUP;
                else
                    w.func = FUNC_TICK;
                w.from_mip   = pick_addr();
                w.target_mip = pick_addr();
                case ($urandom_range(5))
                    0: w.pair_distance = 8'd0;
                    1: w.pair_distance = cfg_max_dist - 8'd1;
                    2: w.pair_distance = cfg_max_dist;
                    3: w.pair_distance = 8'd255;
                    4: w.pair_distance = 8'($urandom_range(255));
                    default: w.pair_distance = 8'($urandom_range(3));
                endcase
                // mostly slow time, some jumps past the timeout, rare arbitrary values
                case ($urandom_range(19))
                    0: run_clock = $urandom;
                    1, 2, 3: run_clock += $urandom_range(cfg_timeout + 4);
                    default: run_clock += $urandom_range(1);
                endcase
                w.now_seconds = run_clock;
                send_word(w, 1'b0, none, phases[p].idle_pct);
            end
        end

        drain_results();
        repeat (ADDR_COUNT + 16) @(posedge i_clk);
        if (err_count == 0 && route_exp_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
src/dvrt_pkg.sv
src/dvrt_ram.sv
src/dvrt_front.sv
src/dvrt_back.sv
src/distance_vector_route_table.sv
verif/distance_vector_route_table_tb.sv
